@@ design/dmpf_pkg.sv @@
`default_nettype none

package dmpf_pkg;

    // Field widths fixed by the interface
    localparam int OFFSET_W    = 32;
    localparam int VRAM_W      = 29;
    localparam int FRAME_OUT_W = 28;
    localparam int DIM_W       = 16;
    localparam int DEPTH_W     = 8;
    localparam int BPP_W       = 3;
    localparam int CNT_W       = 6;

    localparam logic [VRAM_W-1:0] VRAM_RESET = VRAM_W'(16777216);

    // Command codes
    localparam logic CMD_SET_MODE = 1'b0;
    localparam logic CMD_FLIP     = 1'b1;

    // Supported pixel depths
    localparam logic [DEPTH_W-1:0] DEPTH_8  = 8'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 8'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 8'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 8'd32;

    // Full-width pass through the divider, one quotient bit per cycle
    localparam logic [CNT_W-1:0] STEPS_FULL = CNT_W'(OFFSET_W);

    // Divider control and status
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

@@ design/display_mode_and_page_flip.sv @@
`default_nettype none

// Display mode and page flip unit. Each beat on the s_ channel is either a set-mode
// command (width, height, bits per pixel) or a flip command (byte offset of the new
// surface), and yields exactly one m_ beat that reports whether it was applied and the
// current pitch, frame size, start column/row and visible surface. A set-mode goes
// from acceptance to result through the pitch, one registered pitch-by-height
// multiply and the memory check. A flip uses one shared restoring divider, which
// computes the row as offset / pitch over the full 32-bit offset and then the
// column (remainder / bytes per pixel) over PITCH_W bits of the remainder.
// A rejected flip skips the divider. One command is in flight at a time: s_ready
// is high only when the unit is idle and no result is waiting. The video memory size
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while the unit
// is idle, as the unit does not enforce this. Reset sets it to 16 MiB.
module display_mode_and_page_flip #(
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 5120
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire  [dmpf_pkg::VRAM_W-1:0]           cfg_wr_data,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_command,
    input  wire  [dmpf_pkg::DIM_W-1:0]            s_mode_width,
    input  wire  [dmpf_pkg::DIM_W-1:0]            s_mode_height,
    input  wire  [dmpf_pkg::DEPTH_W-1:0]          s_pixel_depth,
    input  wire  [dmpf_pkg::OFFSET_W-1:0]         s_surface_offset,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_accepted,
    output logic [dmpf_pkg::DIM_W-1:0]            m_line_pitch,
    output logic [dmpf_pkg::FRAME_OUT_W-1:0]      m_frame_bytes,
    output logic [dmpf_pkg::DIM_W-1:0]            m_start_column,
    output logic [dmpf_pkg::DIM_W-1:0]            m_start_row,
    output logic [dmpf_pkg::OFFSET_W-1:0]         m_visible_surface
);
    import dmpf_pkg::*;

    localparam int PITCH_W = $clog2(4 * MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W  = PITCH_W + H_W;
    localparam int CMP_W   = OFFSET_W + 1;
    localparam int RAW_W   = DIM_W + BPP_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PITCH = 7'b0000010,
        S_PROD  = 7'b0000100,
        S_MODE  = 7'b0001000,
        S_ROW   = 7'b0010000,
        S_COL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;

    // Architectural state
    logic [VRAM_W-1:0]   vram_reg;
    logic [PITCH_W-1:0]  cur_pitch_reg;
    logic [VRAM_W-1:0]   cur_frame_reg;
    logic [BPP_W-1:0]    cur_bpp_reg;
    logic [OFFSET_W-1:0] cur_surface_reg;
    logic [DIM_W-1:0]    cur_column_reg;
    logic [DIM_W-1:0]    cur_row_reg;
    logic                accepted_reg;

    // Captured command and work registers
    logic [DIM_W-1:0]    width_reg;
    logic [H_W-1:0]      height_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic                mode_ok_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIM_W-1:0]    row_reg;

    // Divider hookup
    div_ctl_t            div_ctl;
    div_sts_t            div_sts;
    logic                div_start_reg;
    logic [CNT_W-1:0]    div_steps_reg;
    logic [OFFSET_W-1:0] div_dend_reg;
    logic [PITCH_W-1:0]  div_dvs_reg;
    logic [OFFSET_W-1:0] div_quo;
    logic [PITCH_W-1:0]  div_rem;

    logic                in_beat;
    logic                out_beat;
    logic                depth_ok;
    logic                mode_ok;
    logic                flip_ok;
    logic [RAW_W-1:0]    pitch_raw;
    logic [RAW_W-1:0]    pitch_rnd;
    logic                fits_vram;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Check a new command against the limits on the way in
    always_comb begin
        depth_ok = (s_pixel_depth == DEPTH_8) || (s_pixel_depth == DEPTH_16) ||
                   (s_pixel_depth == DEPTH_24) || (s_pixel_depth == DEPTH_32);
        mode_ok  = depth_ok &&
                   (s_mode_width != '0) && (s_mode_width <= DIM_W'(MAX_WIDTH)) &&
                   (s_mode_height != '0) && (s_mode_height <= DIM_W'(MAX_HEIGHT));
        flip_ok  = (cur_pitch_reg != '0) &&
                   ((CMP_W'(s_surface_offset) + CMP_W'(cur_frame_reg)) <= CMP_W'(vram_reg));
    end

    // Pitch: bytes per pixel times width, rounded up to 4 bytes
    always_comb begin
        pitch_raw = RAW_W'(bpp_reg) * RAW_W'(width_reg);
        pitch_rnd = (pitch_raw + RAW_W'(3)) & ~RAW_W'(3);
        fits_vram = CMP_W'(prod_reg) < CMP_W'(vram_reg);
    end

    // Video memory size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vram_reg <= VRAM_RESET;
        end else if (cfg_wr_en) begin
            vram_reg <= cfg_wr_data;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_beat) begin
                        if (s_command == CMD_SET_MODE) begin
                            state_reg <= S_PITCH;
                        end else if (flip_ok) begin
                            state_reg     <= S_ROW;
                            div_start_reg <= 1'b1;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_PITCH: state_reg <= S_PROD;
                S_PROD:  state_reg <= S_MODE;
                S_MODE:  state_reg <= S_OUT;
                S_ROW: begin
                    if (div_sts.done) begin
                        state_reg     <= S_COL;
                        div_start_reg <= 1'b1;
                    end
                end
                S_COL: begin
                    if (div_sts.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_beat) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Capture the command and load divider operands
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            width_reg     <= s_mode_width;
            height_reg    <= H_W'(s_mode_height);
            bpp_reg       <= s_pixel_depth[5:3];
            mode_ok_reg   <= mode_ok;
            offset_reg    <= s_surface_offset;
            div_dend_reg  <= s_surface_offset;
            div_dvs_reg   <= cur_pitch_reg;
            div_steps_reg <= STEPS_FULL;
        end else if (state_reg == S_ROW && div_sts.done) begin
            row_reg       <= DIM_W'(div_quo);
            div_dend_reg  <= {div_rem, {(OFFSET_W - PITCH_W){1'b0}}};
            div_dvs_reg   <= PITCH_W'(cur_bpp_reg);
            div_steps_reg <= CNT_W'(PITCH_W);
        end
        if (state_reg == S_PITCH) begin
            pitch_reg <= PITCH_W'(pitch_rnd);
        end
        if (state_reg == S_PROD) begin
            prod_reg <= PROD_W'(pitch_reg) * PROD_W'(height_reg);
        end
    end

    // Commit state and the accepted flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pitch_reg   <= '0;
            cur_frame_reg   <= '0;
            cur_bpp_reg     <= '0;
            cur_surface_reg <= '0;
            cur_column_reg  <= '0;
            cur_row_reg     <= '0;
            accepted_reg    <= 1'b0;
        end else begin
            if (state_reg == S_IDLE && in_beat) begin
                accepted_reg <= 1'b0;
            end
            if (state_reg == S_MODE && mode_ok_reg && fits_vram) begin
                cur_pitch_reg   <= pitch_reg;
                cur_frame_reg   <= VRAM_W'(prod_reg);
                cur_bpp_reg     <= bpp_reg;
                cur_surface_reg <= '0;
                cur_column_reg  <= '0;
                cur_row_reg     <= '0;
                accepted_reg    <= 1'b1;
            end
            if (state_reg == S_COL && div_sts.done) begin
                cur_row_reg     <= row_reg;
                cur_column_reg  <= DIM_W'(div_quo);
                cur_surface_reg <= offset_reg;
                accepted_reg    <= 1'b1;
            end
        end
    end

    assign div_ctl.start = div_start_reg;
    assign div_ctl.steps = div_steps_reg;

    dmpf_div #(
        .DVS_W (PITCH_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .dividend  (div_dend_reg),
        .divisor   (div_dvs_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Handshake and result beat
    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = (state_reg == S_OUT);
    assign m_accepted        = accepted_reg;
    assign m_line_pitch      = DIM_W'(cur_pitch_reg);
    assign m_frame_bytes     = FRAME_OUT_W'(cur_frame_reg);
    assign m_start_column    = cur_column_reg;
    assign m_start_row       = cur_row_reg;
    assign m_visible_surface = cur_surface_reg;

endmodule

`default_nettype wire

@@ design/dmpf_div.sv @@
`default_nettype none

module dmpf_div #(
    parameter int DVS_W = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  dmpf_pkg::div_ctl_t                 ctl,
    input  wire  [dmpf_pkg::OFFSET_W-1:0]      dividend,
    input  wire  [DVS_W-1:0]                   divisor,
    output dmpf_pkg::div_sts_t                 sts,
    output logic [dmpf_pkg::OFFSET_W-1:0]      quotient,
    output logic [DVS_W-1:0]                   remainder
);
    import dmpf_pkg::*;

    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [OFFSET_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[OFFSET_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[OFFSET_W-2:0], fits};
    end

    // Control: count steps down, pulse done after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then iterate
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ design/dmpf_checker.sv @@
`default_nettype none

module dmpf_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_ready,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire                                m_accepted,
    input wire [dmpf_pkg::DIM_W-1:0]          m_line_pitch,
    input wire [dmpf_pkg::FRAME_OUT_W-1:0]    m_frame_bytes,
    input wire [dmpf_pkg::DIM_W-1:0]          m_start_column,
    input wire [dmpf_pkg::DIM_W-1:0]          m_start_row,
    input wire [dmpf_pkg::OFFSET_W-1:0]       m_visible_surface
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accepted) &&
            $stable(m_line_pitch) && $stable(m_frame_bytes) &&
            $stable(m_start_column) && $stable(m_start_row) &&
            $stable(m_visible_surface))
        else $error("result beat changed while stalled");

    // One command at a time: never ready while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // Surface at offset zero shows from the origin
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_visible_surface == '0) |-> (m_start_row == '0) && (m_start_column == '0))
        else $error("zero surface with nonzero start position");

    // Pitch stays 4-byte aligned
    a_pitch_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_pitch[1:0] == 2'b00))
        else $error("line pitch not 4-byte aligned");

endmodule

bind display_mode_and_page_flip dmpf_checker u_dmpf_checker (.*);

`default_nettype wire

@@ dv/display_mode_and_page_flip_tb.sv @@
`default_nettype none

module display_mode_and_page_flip_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmpf_pkg::*;

    localparam int MODE_MAX_WIDTH  = 8192;
    localparam int MODE_MAX_HEIGHT = 5120;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_BEATS     = 200;
    localparam int MAX_REPORTS     = 10;
    localparam int LONG_HOLD_OFF   = 400;

    typedef struct packed {
        logic                command;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [DEPTH_W-1:0]  depth;
        logic [OFFSET_W-1:0] offset;
    } display_cmd_t;

    typedef struct packed {
        logic                   accepted;
        logic [DIM_W-1:0]       pitch;
        logic [FRAME_OUT_W-1:0] frame;
        logic [DIM_W-1:0]       column;
        logic [DIM_W-1:0]       row;
        logic [OFFSET_W-1:0]    surface;
    } display_state_t;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   cfg_wr_en        = 1'b0;
    logic [VRAM_W-1:0]      cfg_wr_data      = '0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic                   s_command        = CMD_SET_MODE;
    logic [DIM_W-1:0]       s_mode_width     = '0;
    logic [DIM_W-1:0]       s_mode_height    = '0;
    logic [DEPTH_W-1:0]     s_pixel_depth    = '0;
    logic [OFFSET_W-1:0]    s_surface_offset = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic                   m_accepted;
    logic [DIM_W-1:0]       m_line_pitch;
    logic [FRAME_OUT_W-1:0] m_frame_bytes;
    logic [DIM_W-1:0]       m_start_column;
    logic [DIM_W-1:0]       m_start_row;
    logic [OFFSET_W-1:0]    m_visible_surface;

    // Shadow of the display registers, updated as each beat is accepted
    logic [VRAM_W-1:0]   vram_bytes    = VRAM_RESET;
    int unsigned         mode_depth    = 0;
    int unsigned         mode_pitch    = 0;
    int unsigned         frame_size    = 0;
    logic [OFFSET_W-1:0] shown_surface = '0;
    logic [DIM_W-1:0]    shown_column  = '0;
    logic [DIM_W-1:0]    shown_row     = '0;

    display_state_t expected_display_state[$];
    int             mismatch_count = 0;
    bit             no_idle        = 1'b0;
    int             hold_off_req   = 0;

    display_mode_and_page_flip #(
        .MAX_WIDTH  (MODE_MAX_WIDTH),
        .MAX_HEIGHT (MODE_MAX_HEIGHT)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_mode_width      (s_mode_width),
        .s_mode_height     (s_mode_height),
        .s_pixel_depth     (s_pixel_depth),
        .s_surface_offset  (s_surface_offset),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_line_pitch      (m_line_pitch),
        .m_frame_bytes     (m_frame_bytes),
        .m_start_column    (m_start_column),
        .m_start_row       (m_start_row),
        .m_visible_surface (m_visible_surface)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one command to the shadow registers and return the state it reports
    function automatic display_state_t apply_display_cmd(input display_cmd_t c);
        display_state_t  r;
        int unsigned     bpp;
        int unsigned     pitch;
        longint unsigned size;
        logic            ok;
        ok = 1'b0;
        if (c.command == CMD_SET_MODE) begin
            bpp   = (int'(c.depth) + 7) / 8;
            pitch = (bpp * 32'(c.width) + 3) & 32'hFFFF_FFFC;
            size  = 64'(pitch) * 64'(c.height);
            if ((c.depth == DEPTH_8 || c.depth == DEPTH_16 || c.depth == DEPTH_24 ||
                 c.depth == DEPTH_32) &&
                c.width != 0 && c.width <= MODE_MAX_WIDTH &&
                c.height != 0 && c.height <= MODE_MAX_HEIGHT &&
                size < 64'(vram_bytes)) begin
                ok            = 1'b1;
                mode_depth    = 32'(c.depth);
                mode_pitch    = pitch;
                frame_size    = 32'(size);
                shown_surface = '0;
                shown_column  = '0;
                shown_row     = '0;
            end
        end else if (mode_pitch != 0 &&
                     64'(c.offset) + 64'(frame_size) <= 64'(vram_bytes)) begin
            bpp           = (mode_depth + 7) / 8;
            ok            = 1'b1;
            shown_row     = 16'(c.offset / mode_pitch);
            shown_column  = 16'((c.offset % mode_pitch) / bpp);
            shown_surface = c.offset;
        end
        r.accepted = ok;
        r.pitch    = 16'(mode_pitch);
        r.frame    = 28'(frame_size);
        r.column   = shown_column;
        r.row      = shown_row;
        r.surface  = shown_surface;
        return r;
    endfunction

    function automatic display_cmd_t mode_cmd(input int w, input int h, input int d);
        display_cmd_t c;
        c         = '0;
        c.command = CMD_SET_MODE;
        c.width   = 16'(w);
        c.height  = 16'(h);
        c.depth   = 8'(d);
        return c;
    endfunction

    function automatic display_cmd_t flip_cmd(input logic [OFFSET_W-1:0] offset);
        display_cmd_t c;
        c         = '0;
        c.command = CMD_FLIP;
        c.offset  = offset;
        return c;
    endfunction

    // Any field value at all, mostly rejected
    function automatic display_cmd_t noise_cmd();
        display_cmd_t c;
        c.command = 1'($urandom_range(1));
        c.width   = 16'($urandom_range(65535));
        c.height  = 16'($urandom_range(65535));
        c.depth   = 8'($urandom_range(255));
        c.offset  = $urandom;
        return c;
    endfunction

    // Legal depth and width, height picked to fit the memory most of the time
    function automatic display_cmd_t random_mode_cmd();
        logic [DEPTH_W-1:0] depths [4];
        int unsigned        w;
        int unsigned        pitch;
        int unsigned        hmax;
        int unsigned        h;
        depths = '{DEPTH_8, DEPTH_16, DEPTH_24, DEPTH_32};
        w      = ($urandom_range(99) < 80) ? $urandom_range(1, 1024)
                                           : $urandom_range(1, MODE_MAX_WIDTH);
        h      = 0;
        mode_cmd_depth: begin
        end
        pitch = 0;
        hmax  = 0;
        begin
            int d;
            d     = int'(depths[$urandom_range(3)]);
            pitch = (((d + 7) / 8) * w + 3) & 32'hFFFF_FFFC;
            hmax  = (vram_bytes == 0) ? 0 : (vram_bytes - 1) / pitch;
            if (hmax > MODE_MAX_HEIGHT) hmax = MODE_MAX_HEIGHT;
            if (hmax == 0) h = $urandom_range(1, MODE_MAX_HEIGHT);
            else if ($urandom_range(99) < 10) h = hmax + 1;
            else h = $urandom_range(1, hmax);
            return mode_cmd(w, h, d);
        end
    endfunction

    // Offsets inside the memory, at its edge, just past it, or anywhere
    function automatic display_cmd_t random_flip_cmd();
        int unsigned span;
        int unsigned pick;
        pick = $urandom_range(99);
        if (mode_pitch == 0 || frame_size > vram_bytes || pick < 8) return flip_cmd($urandom);
        span = vram_bytes - frame_size;
        if (pick < 16) return flip_cmd(span);
        if (pick < 24) return flip_cmd(span + 1);
        if (pick < 40) return flip_cmd($urandom_range(span / mode_pitch) * mode_pitch);
        return flip_cmd($urandom_range(span));
    endfunction

    function automatic string state_text(input display_state_t s);
        return $sformatf("acc=%0d pitch=%0d frame=%0d col=%0d row=%0d surf=0x%08h",
                         s.accepted, s.pitch, s.frame, s.column, s.row, s.surface);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Offer one beat, hold it until accepted, then record what it should report
    task automatic send_beat(input display_cmd_t c);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= c.command;
        s_mode_width     <= c.width;
        s_mode_height    <= c.height;
        s_pixel_depth    <= c.depth;
        s_surface_offset <= c.offset;
        do @(posedge aclk); while (!s_ready);
        expected_display_state.push_back(apply_display_cmd(c));
    endtask

    // Drop valid and wait until every expected beat is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_display_state.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vram(input logic [VRAM_W-1:0] bytes);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge aclk);
        vram_bytes = bytes;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Flip with no mode set, then mode requests refused for their width, height or depth
    task automatic test_flip_without_mode();
        send_beat(flip_cmd('0));
        send_beat(flip_cmd('1));
        send_beat(mode_cmd(0, 480, 32));
        send_beat(mode_cmd(640, 0, 32));
        send_beat(mode_cmd(640, 480, 0));
        send_beat(mode_cmd(640, 480, 255));
        send_beat(mode_cmd(640, 480, 12));
        send_beat(mode_cmd(MODE_MAX_WIDTH + 1, 480, 8));
        send_beat(mode_cmd(640, MODE_MAX_HEIGHT + 1, 8));
        send_beat(mode_cmd(65535, 65535, 32));
    endtask

    // Largest width against the memory edge, smallest mode, pitch rounding
    task automatic test_mode_limits();
        send_beat(mode_cmd(MODE_MAX_WIDTH, 511, 32));
        send_beat(mode_cmd(MODE_MAX_WIDTH, 512, 32));
        send_beat(mode_cmd(1, 1, 24));
        send_beat(mode_cmd(MODE_MAX_WIDTH, MODE_MAX_HEIGHT, 8));
        send_beat(mode_cmd(3, MODE_MAX_HEIGHT, 16));
    endtask

    // Last frame that fits, one byte past it, unaligned offset, no wrap of the sum
    task automatic test_flip_bounds();
        send_beat(flip_cmd(vram_bytes - frame_size));
        send_beat(flip_cmd(vram_bytes - frame_size + 1));
        send_beat(flip_cmd(13));
        send_beat(flip_cmd('1));
    endtask

    // Register at its top, at zero and at the nominal maximum
    task automatic test_vram_extremes();
        write_vram('1);
        send_beat(mode_cmd(1, 1, 8));
        send_beat(flip_cmd(vram_bytes - 4));
        write_vram('0);
        send_beat(mode_cmd(1, 1, 8));
        send_beat(flip_cmd('0));
        write_vram(29'd268435456);
        send_beat(mode_cmd(MODE_MAX_WIDTH, MODE_MAX_HEIGHT, 32));
        send_beat(flip_cmd(vram_bytes - frame_size));
    endtask

    // Mode followed by a run of flips, with some noise, over several memory sizes
    task automatic test_random_sequences();
        logic [VRAM_W-1:0] sizes [6];
        int                n;
        sizes = '{VRAM_RESET, 29'h1FFF_FFFF, 29'd1048576, 29'd268435456, 29'd65536,
                  29'd12345};
        foreach (sizes[i]) begin
            write_vram(sizes[i]);
            no_idle = (i == 1);
            n = 0;
            while (n < PHASE_BEATS) begin
                if ($urandom_range(99) < 12) begin
                    send_beat(noise_cmd());
                    n++;
                end else begin
                    send_beat(random_mode_cmd());
                    n++;
                    repeat ($urandom_range(1, 8)) begin
                        send_beat(random_flip_cmd());
                        n++;
                    end
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Stall the result side for a long stretch while beats keep coming
    task automatic test_backpressure();
        wait_for_results();
        hold_off_req = LONG_HOLD_OFF;
        send_beat(random_mode_cmd());
        repeat (7) send_beat(random_flip_cmd());
        wait_for_results();
        send_beat(random_flip_cmd());
        send_beat(random_mode_cmd());
    endtask

    // Drive result-side ready: long hold-off on request, otherwise random gaps
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req > 0) begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 7);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        display_state_t got;
        display_state_t exp_state;
        string          bad;
        if (aresetn && m_valid && m_ready) begin
            got.accepted = m_accepted;
            got.pitch    = m_line_pitch;
            got.frame    = m_frame_bytes;
            got.column   = m_start_column;
            got.row      = m_start_row;
            got.surface  = m_visible_surface;
            if (expected_display_state.size() == 0) begin
                report_mismatch({"unexpected beat ", state_text(got)});
            end else begin
                exp_state = expected_display_state.pop_front();
                bad = "";
                if (got.accepted !== exp_state.accepted) bad = {bad, " accepted"};
                if (got.pitch !== exp_state.pitch) bad = {bad, " line_pitch"};
                if (got.frame !== exp_state.frame) bad = {bad, " frame_bytes"};
                if (got.column !== exp_state.column) bad = {bad, " start_column"};
                if (got.row !== exp_state.row) bad = {bad, " start_row"};
                if (got.surface !== exp_state.surface) bad = {bad, " visible_surface"};
                if (bad.len() != 0) begin
                    report_mismatch($sformatf("wrong%s: exp %s, got %s", bad,
                                              state_text(exp_state), state_text(got)));
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_flip_without_mode();
        test_mode_limits();
        test_flip_bounds();
        test_vram_extremes();
        test_random_sequences();
        test_backpressure();
        wait_for_results();
        if (mismatch_count == 0 && expected_display_state.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
